/* src/bes_pkg.sv */
// shared types, codes and constants of the blink envelope sequencer
// no dependencies; every other file of the block imports this package

package bes_pkg;

   // channel and port widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // shared divider widths
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // fixed values of the envelope
   localparam logic [6:0] FULL_OPEN        = 7'd100;
   localparam logic [7:0] LAST_VALID_SHAPE = 8'd6;

   // x / 100 as (x * 5243) >> 19, exact for x below 25600
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // register reset values
   localparam logic [15:0] RST_CLOSING_TIME = 16'd80;
   localparam logic [15:0] RST_CLOSED_TIME  = 16'd50;
   localparam logic [15:0] RST_OPENING_TIME = 16'd90;
   localparam logic [23:0] RST_MIN_GAP      = 24'd3000;
   localparam logic [23:0] RST_MAX_GAP      = 24'd8000;
   localparam logic [2:0]  RST_SLEEPY_CODE  = 3'd0;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CLOSING = 2'd1,
      PH_CLOSED  = 2'd2,
      PH_OPENING = 2'd3
   } phase_type;

   // where a new open factor comes from
   typedef enum logic [1:0] {
      FSRC_FULL,
      FSRC_ZERO,
      FSRC_DOWN,
      FSRC_UP
   } fsrc_type;

   // register index, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_CLOSING_TIME = 3'd0,
      REG_CLOSED_TIME  = 3'd1,
      REG_OPENING_TIME = 3'd2,
      REG_MIN_GAP      = 3'd3,
      REG_MAX_GAP      = 3'd4,
      REG_SLEEPY_CODE  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] closing_time;
      logic [15:0] closed_time;
      logic [15:0] opening_time;
      logic [23:0] min_gap;
      logic [23:0] max_gap;
      logic [2:0]  sleepy_code;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic      capture;
      logic      prep;
      logic      div_start;
      logic      div_mod;
      logic      set_next;
      logic      set_phase;
      phase_type phase_val;
      logic      set_start;
      logic      set_active;
      logic      active_val;
      logic      set_factor;
      fsrc_type  factor_src;
      logic      lid_mul;
      logic      out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic      forced;
      logic      active;
      logic      err_shape;
      logic      next_zero;
      logic      span_nz;
      phase_type phase;
      logic      elapsed_ge;
      logic      due;
      logic      div_busy;
      logic      out_free;
   } sts_type;

endpackage

/* src/bes_csr.sv */
// register block of the blink envelope sequencer with its apb-style port
// depends on bes_pkg

module bes_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output bes_pkg::cfg_type               cfg
);
   import bes_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx        = csr_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_CLOSING_TIME: cfg_in.closing_time = csr_pwdata[15:0];
            REG_CLOSED_TIME:  cfg_in.closed_time  = csr_pwdata[15:0];
            REG_OPENING_TIME: cfg_in.opening_time = csr_pwdata[15:0];
            REG_MIN_GAP:      cfg_in.min_gap      = csr_pwdata[23:0];
            REG_MAX_GAP:      cfg_in.max_gap      = csr_pwdata[23:0];
            REG_SLEEPY_CODE:  cfg_in.sleepy_code  = csr_pwdata[2:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closing_time <= RST_CLOSING_TIME;
         cfg_ff.closed_time  <= RST_CLOSED_TIME;
         cfg_ff.opening_time <= RST_OPENING_TIME;
         cfg_ff.min_gap      <= RST_MIN_GAP;
         cfg_ff.max_gap      <= RST_MAX_GAP;
         cfg_ff.sleepy_code  <= RST_SLEEPY_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_CLOSING_TIME: csr_prdata = CSR_DATA_W'(cfg_ff.closing_time);
         REG_CLOSED_TIME:  csr_prdata = CSR_DATA_W'(cfg_ff.closed_time);
         REG_OPENING_TIME: csr_prdata = CSR_DATA_W'(cfg_ff.opening_time);
         REG_MIN_GAP:      csr_prdata = CSR_DATA_W'(cfg_ff.min_gap);
         REG_MAX_GAP:      csr_prdata = CSR_DATA_W'(cfg_ff.max_gap);
         REG_SLEEPY_CODE:  csr_prdata = CSR_DATA_W'(cfg_ff.sleepy_code);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

/* src/bes_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on bes_pkg

module bes_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bes_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [bes_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          busy,
   output logic [bes_pkg::DIV_NUM_W-1:0] quotient,
   output logic [bes_pkg::DIV_DEN_W-1:0] remainder
);
   import bes_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : DIV_DEN_W'(trial);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* src/bes_datapath.sv */
// datapath of the blink envelope sequencer: item registers, blink state,
// scheduling and ramp arithmetic, output register; depends on bes_pkg, bes_div

module bes_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bes_pkg::cmd_type               cmd,
   output bes_pkg::sts_type               sts,
   input  bes_pkg::cfg_type               cfg,
   input  logic [bes_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bes_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bes_pkg::*;

   // captured item
   logic        req_type_ff, req_type_in;
   logic [31:0] now_ff, now_in;
   logic [7:0]  shape_ff, shape_in;
   logic [31:0] rnd_ff, rnd_in;
   logic [7:0]  base_ff, base_in;

   // blink state
   phase_type   phase_ff, phase_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] next_ff, next_in;
   logic        active_ff, active_in;
   logic [6:0]  factor_ff, factor_in;

   // working registers
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] nm_ff, nm_in;
   logic [14:0] prod_ff, prod_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // divider connections
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_busy;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [DIV_DEN_W-1:0] div_rem;

   logic [23:0] span;
   logic        span_nz;
   logic [15:0] dur;
   logic [22:0] ratio_num;
   logic [31:0] due_diff;
   logic [27:0] lid_prod;
   logic [7:0]  lid_val;
   logic [6:0]  factor_new;
   logic [31:0] offset;

   // gap range, empty when max is not above min
   assign span    = (cfg.max_gap > cfg.min_gap) ? (cfg.max_gap - cfg.min_gap) : 24'd0;
   assign span_nz = span != 24'd0;

   // duration of the phase in progress
   always_comb begin
      unique case (phase_ff)
         PH_IDLE:    dur = 16'd0;
         PH_CLOSING: dur = cfg.closing_time;
         PH_CLOSED:  dur = cfg.closed_time;
         PH_OPENING: dur = cfg.opening_time;
      endcase
   end

   // ramp numerator, only used while elapsed is below a 16-bit duration
   assign ratio_num = 23'(elapsed_ff[15:0]) * 23'(FULL_OPEN);
   assign due_diff  = now_ff - next_ff;

   // divider operands: gap modulo or ramp ratio
   assign div_num = cmd.div_mod ? rnd_ff : DIV_NUM_W'(ratio_num);
   assign div_den = cmd.div_mod ? span : DIV_DEN_W'(dur);

   bes_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // scaled lid from the registered product
   assign lid_prod = 28'(prod_ff) * 28'(RECIP_100);
   assign lid_val  = lid_prod[RECIP_SHIFT +: 8];

   assign offset = span_nz ? 32'(div_rem) : 32'd0;

   always_comb begin
      unique case (cmd.factor_src)
         FSRC_FULL: factor_new = FULL_OPEN;
         FSRC_ZERO: factor_new = 7'd0;
         FSRC_DOWN: factor_new = FULL_OPEN - div_quo[6:0];
         FSRC_UP:   factor_new = div_quo[6:0];
      endcase
   end

   // next-value logic
   always_comb begin
      req_type_in  = req_type_ff;
      now_in       = now_ff;
      shape_in     = shape_ff;
      rnd_in       = rnd_ff;
      base_in      = base_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      next_in      = next_ff;
      active_in    = active_ff;
      factor_in    = factor_ff;
      elapsed_in   = elapsed_ff;
      nm_in        = nm_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // input transfer
      if (cmd.capture) begin
         req_type_in = req_tuser;
         now_in      = req_tdata[31:0];
         shape_in    = req_tdata[39:32];
         rnd_in      = req_tdata[71:40];
         base_in     = req_tdata[79:72];
      end

      if (cmd.prep) begin
         elapsed_in = now_ff - start_ff;
         nm_in      = now_ff + 32'(cfg.min_gap);
      end

      if (cmd.set_next) begin
         next_in = nm_ff + offset;
      end
      if (cmd.set_phase) begin
         phase_in = cmd.phase_val;
      end
      if (cmd.set_start) begin
         start_in = now_ff;
      end
      if (cmd.set_active) begin
         active_in = cmd.active_val;
      end
      if (cmd.set_factor) begin
         factor_in = factor_new;
      end

      if (cmd.lid_mul) begin
         prod_in = 15'(base_ff) * 15'(factor_ff);
      end

      // output register, a new result wins over a transfer out
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, next_ff, phase_ff, active_ff, factor_ff, lid_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         start_ff     <= '0;
         next_ff      <= '0;
         active_ff    <= 1'b0;
         factor_ff    <= FULL_OPEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         next_ff      <= next_in;
         active_ff    <= active_in;
         factor_ff    <= factor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff <= req_type_in;
      now_ff      <= now_in;
      shape_ff    <= shape_in;
      rnd_ff      <= rnd_in;
      base_ff     <= base_in;
      elapsed_ff  <= elapsed_in;
      nm_ff       <= nm_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to the controller
   assign sts.forced     = req_type_ff;
   assign sts.active     = active_ff;
   assign sts.err_shape  = (shape_ff == 8'(cfg.sleepy_code)) || (shape_ff > LAST_VALID_SHAPE);
   assign sts.next_zero  = next_ff == 32'd0;
   assign sts.span_nz    = span_nz;
   assign sts.phase      = phase_ff;
   assign sts.elapsed_ge = elapsed_ff >= 32'(dur);
   assign sts.due        = ~due_diff[31];
   assign sts.div_busy   = div_busy;
   assign sts.out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/bes_ctrl.sv */
// controller of the blink envelope sequencer: steps one item through
// prepare, schedule, phase update and output; depends on bes_pkg

module bes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bes_pkg::sts_type sts,
   output bes_pkg::cmd_type cmd
);
   import bes_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DECIDE,
      S_PLAN,
      S_PLAN_WAIT,
      S_PLAN_SET,
      S_PHASE,
      S_RATIO_WAIT,
      S_RATIO_SET,
      S_LID,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   // after scheduling: 1 continue with the phase update, 0 go to output
   logic      ret_phase_ff, ret_phase_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      ret_phase_in = ret_phase_ff;
      cmd          = '0;
      cmd.phase_val  = PH_IDLE;
      cmd.factor_src = FSRC_FULL;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end

         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DECIDE;
         end

         // forced request, sleepy or bad shape, missing schedule
         S_DECIDE: begin
            priority if (sts.forced) begin
               if (!sts.active) begin
                  cmd.set_phase  = 1'b1;
                  cmd.phase_val  = PH_CLOSING;
                  cmd.set_start  = 1'b1;
                  cmd.set_active = 1'b1;
                  cmd.active_val = 1'b1;
                  cmd.set_factor = 1'b1;
                  cmd.factor_src = FSRC_FULL;
               end
               state_in = S_LID;
            end else if (sts.err_shape) begin
               cmd.set_phase  = 1'b1;
               cmd.phase_val  = PH_IDLE;
               cmd.set_active = 1'b1;
               cmd.active_val = 1'b0;
               cmd.set_factor = 1'b1;
               cmd.factor_src = FSRC_FULL;
               ret_phase_in   = 1'b0;
               state_in       = S_PLAN;
            end else if (sts.next_zero) begin
               ret_phase_in = 1'b1;
               state_in     = S_PLAN;
            end else begin
               state_in = S_PHASE;
            end
         end

         // random gap offset through the divider
         S_PLAN: begin
            if (sts.span_nz) begin
               cmd.div_start = 1'b1;
               cmd.div_mod   = 1'b1;
               state_in      = S_PLAN_WAIT;
            end else begin
               state_in = S_PLAN_SET;
            end
         end

         S_PLAN_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_PLAN_SET;
            end
         end

         S_PLAN_SET: begin
            cmd.set_next = 1'b1;
            state_in     = ret_phase_ff ? S_PHASE : S_LID;
         end

         S_PHASE: begin
            state_in = S_LID;
            unique case (sts.phase)
               PH_IDLE: begin
                  cmd.set_factor = 1'b1;
                  cmd.factor_src = FSRC_FULL;
                  if (sts.due) begin
                     cmd.set_phase  = 1'b1;
                     cmd.phase_val  = PH_CLOSING;
                     cmd.set_start  = 1'b1;
                     cmd.set_active = 1'b1;
                     cmd.active_val = 1'b1;
                  end
               end
               PH_CLOSING: begin
                  if (sts.elapsed_ge) begin
                     cmd.set_phase  = 1'b1;
                     cmd.phase_val  = PH_CLOSED;
                     cmd.set_start  = 1'b1;
                     cmd.set_factor = 1'b1;
                     cmd.factor_src = FSRC_ZERO;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_RATIO_WAIT;
                  end
               end
               PH_CLOSED: begin
                  cmd.set_factor = 1'b1;
                  cmd.factor_src = FSRC_ZERO;
                  if (sts.elapsed_ge) begin
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = PH_OPENING;
                     cmd.set_start = 1'b1;
                  end
               end
               PH_OPENING: begin
                  if (sts.elapsed_ge) begin
                     cmd.set_phase  = 1'b1;
                     cmd.phase_val  = PH_IDLE;
                     cmd.set_start  = 1'b1;
                     cmd.set_active = 1'b1;
                     cmd.active_val = 1'b0;
                     cmd.set_factor = 1'b1;
                     cmd.factor_src = FSRC_FULL;
                     ret_phase_in   = 1'b0;
                     state_in       = S_PLAN;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_RATIO_WAIT;
                  end
               end
            endcase
         end

         S_RATIO_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_RATIO_SET;
            end
         end

         S_RATIO_SET: begin
            cmd.set_factor = 1'b1;
            cmd.factor_src = (sts.phase == PH_CLOSING) ? FSRC_DOWN : FSRC_UP;
            state_in       = S_LID;
         end

         S_LID: begin
            cmd.lid_mul = 1'b1;
            state_in    = S_DONE;
         end

         // wait for room in the output register
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_phase_ff <= ret_phase_in;
      end
   end

endmodule

/* src/blink_envelope_sequencer.sv */
// blink envelope sequencer, top level: register block, controller, datapath
// depends on bes_pkg, bes_csr, bes_ctrl, bes_datapath (and bes_div below it)
//
//   group  direction  transfer carries
//   req    in         one tick or forced blink request
//   rsp    out        one lid result per request
//   csr    in/out     apb-style register writes and reads
//
// a forced request skips scheduling and the phase update; the ramp ratio or the gap
// modulo runs through the shared 32-step divider, and both can run for the same item
// reset is synchronous and active high; it restores register defaults, idle phase
// and an unscheduled next blink; req_tready is high only between items,
// and a held rsp transfer does not stop the next req transfer from being taken

module blink_envelope_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: now_ms[31:0], shape_code[39:32], random_word[71:40], base_lid[79:72]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bes_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: req_type[0]
   input  logic [0:0]                     req_tuser,
   // rsp_tdata: lid_out[7:0], open_factor[14:8], blinking[15], phase[17:16],
   //            next_blink_ms[49:18], zero fill[55:50]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bes_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bes_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   bes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bes_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* dv/bes_checker.sv */
`timescale 1ns / 100ps
// result checker for the blink envelope sequencer: watches req, rsp and csr transfers,
// keeps its own copy of the envelope state and compares every lid result
// depends on bes_pkg for the phase codes, register indexes and reset values

module bes_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bes_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bes_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             blinks_started
);
   import bes_pkg::*;

   // one lid result, lowest field last so it lines up with rsp_tdata
   typedef struct packed {
      logic [31:0] next_ms;
      phase_type   phase;
      logic        blinking;
      logic [6:0]  factor;
      logic [7:0]  lid;
   } lid_result_type;

   cfg_type     cfg;
   phase_type   ph;
   logic [31:0] start_ms;
   logic [31:0] next_ms;
   logic        active;
   logic [6:0]  factor;

   lid_result_type expected_lids[$];
   int          fails;
   int          checked;
   int          starts;

   // next blink lands a random gap after now; empty or inverted range gives no offset
   task automatic plan_next_blink(input logic [31:0] now, input logic [31:0] rnd);
      logic [31:0] span;
      logic [31:0] offset;
      span = (cfg.max_gap > cfg.min_gap) ? 32'(cfg.max_gap - cfg.min_gap) : 32'd0;
      offset = (span != 32'd0) ? rnd % span : 32'd0;
      next_ms = now + 32'(cfg.min_gap) + offset;
   endtask

   // one periodic tick of the envelope
   task automatic advance_tick(input logic [31:0] now, input logic [7:0] shape,
                               input logic [31:0] rnd);
      logic [31:0] elapsed;
      logic [31:0] since_due;
      if (shape == {5'd0, cfg.sleepy_code} || shape > LAST_VALID_SHAPE) begin
         // sleepy or error shape parks the lid open and reschedules
         ph = PH_IDLE;
         active = 1'b0;
         factor = FULL_OPEN;
         plan_next_blink(now, rnd);
      end else begin
         if (next_ms == 32'd0)
            plan_next_blink(now, rnd);
         elapsed = now - start_ms;
         since_due = now - next_ms;
         case (ph)
            PH_IDLE: begin
               factor = FULL_OPEN;
               if (!since_due[31]) begin
                  ph = PH_CLOSING;
                  start_ms = now;
                  active = 1'b1;
                  starts++;
               end
            end
            PH_CLOSING: begin
               if (elapsed >= 32'(cfg.closing_time)) begin
                  ph = PH_CLOSED;
                  start_ms = now;
                  factor = 7'd0;
               end else begin
                  factor = FULL_OPEN
                           - 7'((elapsed * 32'd100) / 32'(cfg.closing_time));
               end
            end
            PH_CLOSED: begin
               factor = 7'd0;
               if (elapsed >= 32'(cfg.closed_time)) begin
                  ph = PH_OPENING;
                  start_ms = now;
               end
            end
            default: begin
               if (elapsed >= 32'(cfg.opening_time)) begin
                  ph = PH_IDLE;
                  start_ms = now;
                  active = 1'b0;
                  factor = FULL_OPEN;
                  plan_next_blink(now, rnd);
               end else begin
                  factor = 7'((elapsed * 32'd100) / 32'(cfg.opening_time));
               end
            end
         endcase
      end
   endtask

   // apply one request and work out the lid result it produces
   task automatic predict_lid(input logic forced, input logic [31:0] now,
                              input logic [7:0] shape, input logic [31:0] rnd,
                              input logic [7:0] base, output lid_result_type res);
      logic [15:0] prod;
      if (forced) begin
         // a forced blink is dropped while one is already running
         if (!active) begin
            ph = PH_CLOSING;
            start_ms = now;
            active = 1'b1;
            factor = FULL_OPEN;
            starts++;
         end
      end else begin
         advance_tick(now, shape, rnd);
      end
      prod = base * factor;
      res.lid = 8'(prod / 16'd100);
      res.factor = factor;
      res.blinking = active;
      res.phase = ph;
      res.next_ms = next_ms;
   endtask

   always @(posedge clock) begin : watch
      lid_result_type exp_res;
      lid_result_type got_res;
      if (reset) begin
         cfg.closing_time = RST_CLOSING_TIME;
         cfg.closed_time  = RST_CLOSED_TIME;
         cfg.opening_time = RST_OPENING_TIME;
         cfg.min_gap      = RST_MIN_GAP;
         cfg.max_gap      = RST_MAX_GAP;
         cfg.sleepy_code  = RST_SLEEPY_CODE;
         ph = PH_IDLE;
         start_ms = 32'd0;
         next_ms = 32'd0;
         active = 1'b0;
         factor = FULL_OPEN;
         expected_lids.delete();
      end else begin
         // register writes shadowed into the local configuration
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[4:2]))
               REG_CLOSING_TIME: cfg.closing_time = csr_pwdata[15:0];
               REG_CLOSED_TIME:  cfg.closed_time  = csr_pwdata[15:0];
               REG_OPENING_TIME: cfg.opening_time = csr_pwdata[15:0];
               REG_MIN_GAP:      cfg.min_gap      = csr_pwdata[23:0];
               REG_MAX_GAP:      cfg.max_gap      = csr_pwdata[23:0];
               REG_SLEEPY_CODE:  cfg.sleepy_code  = csr_pwdata[2:0];
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_res = lid_result_type'(rsp_tdata[$bits(lid_result_type)-1:0]);
            if (expected_lids.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected lid result: lid %0d factor %0d blinking %0b phase %0d next %h",
                           got_res.lid, got_res.factor, got_res.blinking, got_res.phase,
                           got_res.next_ms);
            end else begin
               exp_res = expected_lids.pop_front();
               checked++;
               if (got_res !== exp_res) begin
                  fails++;
                  if (fails <= 10)
                     $display({"lid result mismatch at %0t: expected lid %0d factor %0d ",
                               "blinking %0b phase %0d next %h, got lid %0d factor %0d ",
                               "blinking %0b phase %0d next %h"}, $realtime,
                              exp_res.lid, exp_res.factor, exp_res.blinking, exp_res.phase,
                              exp_res.next_ms, got_res.lid, got_res.factor,
                              got_res.blinking, got_res.phase, got_res.next_ms);
               end
            end
         end

         // request transfer: predict its lid result
         if (req_tvalid && req_tready) begin
            predict_lid(req_tuser[0], req_tdata[31:0], req_tdata[39:32], req_tdata[71:40],
                        req_tdata[79:72], exp_res);
            expected_lids.push_back(exp_res);
         end
      end
      fail_count     <= fails;
      pending_count  <= expected_lids.size();
      checked_count  <= checked;
      blinks_started <= starts;
   end

endmodule

/* dv/tb_blink_envelope_sequencer.sv */
`timescale 1ns / 100ps
// testbench top for the blink envelope sequencer: clock, reset, request stimulus,
// register settings and idling modes; checking is done by bes_checker
// depends on bes_pkg, bes_checker and the blink_envelope_sequencer rtl

module tb_blink_envelope_sequencer;
   import bes_pkg::*;

   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_FORCED = 1'b1;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_count;
   int checked_count;
   int blinks_started;

   int          gap_pct = 0;
   int          stall_pct = 0;
   int          step_span = 10;
   int          items_sent = 0;
   int          settings_applied = 0;
   logic [2:0]  sleepy_now = RST_SLEEPY_CODE;
   logic [31:0] now_cur = 32'd0;

   blink_envelope_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bes_checker lid_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .blinks_started (blinks_started)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one request transfer, with optional idle cycles ahead of it
   task automatic send_request(input logic kind, input logic [31:0] now,
                               input logic [7:0] shape, input logic [31:0] rnd,
                               input logic [7:0] base);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {base, rnd, shape, now};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // mostly a steadily advancing clock with valid shapes, some noise mixed in
   task automatic send_random();
      logic       kind;
      logic [7:0] shape;
      int         pick;
      if ($urandom_range(99) < 85) begin
         now_cur = now_cur + 32'($urandom_range(step_span));
         kind = ($urandom_range(9) == 0) ? REQ_FORCED : REQ_TICK;
         pick = $urandom_range(99);
         if (pick < 6) begin
            shape = {5'd0, sleepy_now};
         end else if (pick < 11) begin
            shape = 8'($urandom_range(255, 7));
         end else begin
            do shape = 8'($urandom_range(6)); while (shape == {5'd0, sleepy_now});
         end
      end else begin
         now_cur = $urandom;
         kind = 1'($urandom_range(1));
         shape = 8'($urandom_range(255));
      end
      send_request(kind, now_cur, shape, $urandom, 8'($urandom_range(255)));
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_reg(input csr_idx_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait until every result is back and the block sits between items
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || !req_tready);
   endtask

   task automatic apply_setting(input logic [15:0] closing, input logic [15:0] closed,
                                input logic [15:0] opening, input logic [23:0] min_gap,
                                input logic [23:0] max_gap, input logic [2:0] sleepy);
      settle();
      write_reg(REG_CLOSING_TIME, 32'(closing));
      write_reg(REG_CLOSED_TIME, 32'(closed));
      write_reg(REG_OPENING_TIME, 32'(opening));
      write_reg(REG_MIN_GAP, 32'(min_gap));
      write_reg(REG_MAX_GAP, 32'(max_gap));
      write_reg(REG_SLEEPY_CODE, 32'(sleepy));
      sleepy_now = sleepy;
      settings_applied++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, one full blink by hand
      send_request(REQ_TICK, 32'd0, 8'd1, 32'd0, 8'd255);
      send_request(REQ_TICK, 32'd10, 8'd0, 32'hFFFF_FFFF, 8'd0);
      send_request(REQ_TICK, 32'd20, 8'd7, 32'd1234, 8'd128);
      send_request(REQ_TICK, 32'd30, 8'd255, 32'd77, 8'd1);
      send_request(REQ_FORCED, 32'd100, 8'd255, 32'd5, 8'd255);
      send_request(REQ_FORCED, 32'd101, 8'd3, 32'd9, 8'd200);
      send_request(REQ_TICK, 32'd140, 8'd2, 32'd11, 8'd255);
      send_request(REQ_TICK, 32'd180, 8'd2, 32'd12, 8'd255);
      send_request(REQ_TICK, 32'd230, 8'd2, 32'd13, 8'd255);
      send_request(REQ_TICK, 32'd275, 8'd2, 32'd14, 8'd255);
      send_request(REQ_TICK, 32'd320, 8'd2, 32'hDEAD_BEEF, 8'd99);
      send_request(REQ_TICK, 32'hFFFF_FFF0, 8'd3, 32'd0, 8'd170);

      // directed: zero durations, a schedule that wraps onto zero
      apply_setting(16'd0, 16'd0, 16'd0, 24'd16, 24'd16, 3'd6);
      send_request(REQ_TICK, 32'hFFFF_FFF0, 8'd6, 32'h1357_9BDF, 8'd85);
      send_request(REQ_TICK, 32'hFFFF_FFF1, 8'd4, 32'd3, 8'd85);
      send_request(REQ_TICK, 32'd1, 8'd4, 32'd3, 8'd85);
      send_request(REQ_TICK, 32'd1, 8'd4, 32'd3, 8'd85);
      send_request(REQ_TICK, 32'd1, 8'd4, 32'd3, 8'd85);
      send_request(REQ_TICK, 32'd1, 8'd4, 32'd3, 8'd85);
      send_request(REQ_FORCED, 32'd2, 8'd0, 32'd3, 8'd200);
      send_request(REQ_TICK, 32'd2, 8'd6, 32'd3, 8'd200);

      // random phases, each with its own setting and one of four idling modes
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               apply_setting(16'd30, 16'd20, 16'd40, 24'd50, 24'd400, 3'd3);
               step_span = 15;
            end
            1: begin
               apply_setting(16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 3'd6);
               step_span = 3;
            end
            2: begin
               apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 24'hFF_FFFF, 3'd0);
               step_span = 9000;
            end
            3: begin
               apply_setting(16'($urandom_range(100, 1)), 16'($urandom_range(100, 1)),
                             16'($urandom_range(100, 1)), 24'd200, 24'd100, 3'd5);
               step_span = 20;
            end
            4: begin
               apply_setting(16'd1, 16'd1, 16'd1, 24'hFF_FFFF, 24'hFF_FFFF, 3'd1);
               step_span = 4;
            end
            6: begin
               apply_setting(16'd1, 16'hFFFF, 16'd2, 24'd1, 24'd2, 3'd2);
               step_span = 5000;
            end
            default: begin
               apply_setting(16'($urandom_range(300)), 16'($urandom_range(300)),
                             16'($urandom_range(300)), 24'($urandom_range(500)),
                             24'($urandom_range(1000)), 3'($urandom_range(6)));
               step_span = 40;
            end
         endcase
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 86; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 86; end
            default: begin gap_pct = 26; stall_pct = 26; end
         endcase
         // start each phase at a random time, sometimes just before the wrap
         now_cur = ($urandom_range(1) == 0) ? $urandom
                                           : 32'hFFFF_FFFF - 32'($urandom_range(2000));
         repeat (105) send_random();
      end

      settle();
      repeat (100) @(posedge clock);
      $display("covered %0d requests over %0d register settings and four idling modes",
               items_sent, settings_applied);
      $display("checked %0d lid results, %0d blink starts predicted",
               checked_count, blinks_started);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_blink_envelope_sequencer OK");
      else
         $display("tb_blink_envelope_sequencer NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb_blink_envelope_sequencer NOT OK");
      $finish;
   end

endmodule
